/* hdl/lsb_first_bit_packer_macros.svh */
// Assertion helpers for the bit packer. Each macro places one labeled
// concurrent assertion that is clocked on the rising edge and disabled in reset.
`ifndef LSB_FIRST_BIT_PACKER_MACROS_SVH
`define LSB_FIRST_BIT_PACKER_MACROS_SVH

// Same-cycle implication.
`define LBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lbp_pkg.sv */
`default_nettype none

package lbp_pkg;

    // Fixed field widths of the stream items.
    localparam int CODE_BITS = 16;
    localparam int LEN_BITS  = 5;
    localparam int CAP_BITS  = 16;
    localparam int IDX_BITS  = 16;
    localparam int BYTE_BITS = 8;

    // Bit accumulator depth and the width of its fill count.
    localparam int ACC_BITS = 24;
    localparam int CNT_BITS = 5;

    // Packed widths of the stream data buses, padded to whole bytes.
    localparam int S_TDATA_BITS = 24;
    localparam int M_TDATA_BITS = 24;

endpackage

`default_nettype wire

/* hdl/lsb_first_bit_packer.sv */
`default_nettype none

// LSB-first bit packer for a DEFLATE-style compressor.
// The slave stream carries one code per transaction: tdata holds code_value in
// bits 15:0 and code_length in bits 20:16, and tuser holds the reverse flag.
// With the flag set, the code is bit-reversed within its length before it is
// appended above the bits already pending in a 24-bit accumulator.
// The master stream carries one output byte per transaction: tdata holds the
// byte in bits 7:0 and its buffer index in bits 23:8, tuser flags an overflow
// (capacity reached, no byte written), and tlast marks the final transaction
// caused by one input code. Each code yields zero, one or two transactions.
// The capacity register is written through cfg_we and cfg_wdata; the user must
// write it only while idle, since the block itself does not enforce this. A code
// is taken in the idle state; then a small sequencer emits one byte per cycle,
// unless the receiver stalls, through a single shared position compare and increment.
// Each byte is formed in the emit state and then held in the output register.
// A stall on the master side simply holds the output register and the
// sequencer; no byte is lost or repeated. A new code may be accepted while the
// last byte of the previous one still waits in the output register.
// Reset clears the accumulator, bit count and write position and sets the
// capacity to 65535; no clearing pass is needed.
module lsb_first_bit_packer
    import lbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = 16,
    parameter int POSITION_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Capacity register write port.
    input  wire logic                    cfg_we,
    input  wire logic [CAP_BITS-1:0]     cfg_wdata,
    // Code input stream.
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata fields from bit 0 up: code_value[15:0], code_length[20:16], zero pad.
    input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // tuser fields from bit 0 up: reverse_flag[0].
    input  wire logic                    s_axis_tuser,
    // Byte output stream.
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // tdata fields from bit 0 up: out_byte[7:0], byte_index[23:8].
    output logic [M_TDATA_BITS-1:0]      m_axis_tdata,
    // tuser fields from bit 0 up: overflow[0].
    output logic                         m_axis_tuser,
    output logic                         m_axis_tlast
);

    // The reversal works over a word wide enough for the longest code.
    localparam int REV_W   = (MAX_CODE_BITS > CODE_BITS) ? MAX_CODE_BITS : CODE_BITS;
    localparam int SHAMT_W = $clog2(REV_W + 1);
    localparam int WIDE_W  = ACC_BITS + REV_W;
    localparam int CMP_W   = (POSITION_BITS > CAP_BITS) ? POSITION_BITS : CAP_BITS;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [ACC_BITS-1:0]      acc_reg, acc_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [CAP_BITS-1:0]      cap_reg, cap_next;
    logic                     second_reg, second_next;
    logic                     m_valid_reg, m_valid_next;
    logic [BYTE_BITS-1:0]     byte_reg, byte_next;
    logic [IDX_BITS-1:0]      idx_reg, idx_next;
    logic                     ovf_reg, ovf_next;
    logic                     last_reg, last_next;

    // Append datapath: saturate the length, mask, optionally reverse, shift in.
    logic [LEN_BITS-1:0]  len_sat;
    logic [REV_W-1:0]     code_mask;
    logic [REV_W-1:0]     code_masked;
    logic [REV_W-1:0]     code_rev_full;
    logic [SHAMT_W-1:0]   rev_shamt;
    logic [REV_W-1:0]     code_sel;
    logic [WIDE_W-1:0]    code_wide;
    logic [CNT_BITS:0]    cnt_sum;
    logic [ACC_BITS-1:0]  acc_app;
    logic [CNT_BITS-1:0]  cnt_app;

    // Shared emit unit: one capacity compare and one position increment.
    logic                 pos_full;
    logic [CNT_BITS-1:0]  cnt_after;
    logic                 out_free;
    logic                 s_accept;

    always_comb
    begin
        len_sat = (s_axis_tdata[CODE_BITS +: LEN_BITS] > LEN_BITS'(MAX_CODE_BITS))
                  ? LEN_BITS'(MAX_CODE_BITS) : s_axis_tdata[CODE_BITS +: LEN_BITS];
        code_mask   = ~({REV_W{1'b1}} << len_sat);
        code_masked = REV_W'(s_axis_tdata[CODE_BITS-1:0]) & code_mask;
        for (int i = 0; i < REV_W; i++)
        begin
            code_rev_full[i] = code_masked[REV_W-1-i];
        end
        // Bit i of the code lands at REV_W-1-i; shifting down leaves it at len-1-i.
        rev_shamt = SHAMT_W'(REV_W) - SHAMT_W'(len_sat);
        code_sel  = s_axis_tuser ? (code_rev_full >> rev_shamt) : code_masked;
        code_wide = WIDE_W'(code_sel) << cnt_reg;
        // Bits that would land at bit 24 or above are dropped.
        acc_app   = acc_reg | code_wide[ACC_BITS-1:0];
        cnt_sum   = {1'b0, cnt_reg} + (CNT_BITS+1)'(len_sat);
        cnt_app   = (cnt_sum > (CNT_BITS+1)'(ACC_BITS)) ? CNT_BITS'(ACC_BITS)
                                                        : cnt_sum[CNT_BITS-1:0];
    end

    assign pos_full  = CMP_W'(pos_reg) >= CMP_W'(cap_reg);
    assign cnt_after = cnt_reg - CNT_BITS'(BYTE_BITS);
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign s_accept  = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        cap_next     = cfg_we ? cfg_wdata : cap_reg;
        second_next  = second_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        byte_next    = byte_reg;
        idx_next     = idx_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    acc_next    = acc_app;
                    cnt_next    = cnt_app;
                    second_next = 1'b0;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cnt_reg < CNT_BITS'(BYTE_BITS))
                begin
                    // No complete byte pending: this code yields nothing.
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    m_valid_next = 1'b1;
                    idx_next     = IDX_BITS'(pos_reg);
                    if (pos_full)
                    begin
                        // Capacity reached: report it and keep the pending bits.
                        byte_next  = '0;
                        ovf_next   = 1'b1;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        byte_next = acc_reg[BYTE_BITS-1:0];
                        ovf_next  = 1'b0;
                        pos_next  = pos_reg + POSITION_BITS'(1);
                        acc_next  = acc_reg >> BYTE_BITS;
                        cnt_next  = cnt_after;
                        // At most two bytes per code; the rest stays pending.
                        if (second_reg || (cnt_after < CNT_BITS'(BYTE_BITS)))
                        begin
                            last_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            last_next   = 1'b0;
                            second_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            cap_reg     <= {CAP_BITS{1'b1}};
            second_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            byte_reg    <= '0;
            idx_reg     <= '0;
            ovf_reg     <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            cap_reg     <= cap_next;
            second_reg  <= second_next;
            m_valid_reg <= m_valid_next;
            byte_reg    <= byte_next;
            idx_reg     <= idx_next;
            ovf_reg     <= ovf_next;
            last_reg    <= last_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {idx_reg, byte_reg};
    assign m_axis_tuser  = ovf_reg;
    assign m_axis_tlast  = last_reg;

`include "lsb_first_bit_packer_macros.svh"

    // A code occupies the sequencer in the cycle after it is taken.
    `LBP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_accept, !s_axis_tready, "ready right after accept")
    // An overflow item always ends the output of its code.
    `LBP_ASSERT_NOW(a_ovf_is_last, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "overflow not last")
    // The pending bit count never exceeds the accumulator depth.
    `LBP_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_BITS'(ACC_BITS), "bit count overrun")

endmodule

`default_nettype wire
